// File: rtl/fl32ck_pkg.sv
package fl32ck_pkg;

  typedef logic [15:0] word_t;
  typedef logic [31:0] checksum_t;
  typedef logic [23:0] sum_first_t;
  typedef logic [31:0] sum_second_t;
  typedef logic [16:0] fold_t;
  typedef logic [7:0]  count_t;

  localparam sum_first_t  FirstRearm  = 24'h00ffff;
  localparam sum_second_t SecondRearm = 32'h0000ffff;

  // end-around carry fold of the first sum
  function automatic fold_t fold_first(input sum_first_t s);
    fold_t lo;
    fold_t hi;
    lo = {1'b0, s[15:0]};
    hi = {9'b0, s[23:16]};
    return lo + hi;
  endfunction

  // end-around carry fold of the second sum
  function automatic fold_t fold_second(input sum_second_t s);
    fold_t lo;
    fold_t hi;
    lo = {1'b0, s[15:0]};
    hi = {1'b0, s[31:16]};
    return lo + hi;
  endfunction

  // second fold of an already folded sum, low half kept
  function automatic word_t fold_final(input fold_t s);
    return s[15:0] + {15'b0, s[16]};
  endfunction

endpackage

// File: rtl/fl32ck_ifs.sv
interface fl32ck_in_if import fl32ck_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t word;
  logic  last;

  modport source (output valid, output word, output last, input ready);
  modport sink (input valid, input word, input last, output ready);
endinterface

interface fl32ck_out_if import fl32ck_pkg::*; ();
  logic      valid;
  logic      ready;
  checksum_t checksum;

  modport source (output valid, output checksum, input ready);
  modport sink (input valid, input checksum, output ready);
endinterface

// File: rtl/fletcher32_checksum.sv
// a last word goes from the input stage via the fold stage to the result stage
// throughput: one word per cycle, back to back, stalling only while a last word waits
//   behind full fold and result stages and out_ch.ready is low
// the running sums update in the second stage; the final fold sits in the third
// reset (synchronous, rst_n low) empties all stages and re-arms both sums to 0xffff
module fletcher32_checksum import fl32ck_pkg::*; #(
  parameter int BLOCK_WORDS = 180
) (
  input logic              clk,
  input logic              rst_n,
  fl32ck_in_if.sink        in_ch,
  fl32ck_out_if.source     out_ch
);

  localparam count_t BlockWordsC = count_t'(BLOCK_WORDS);

  // input stage
  logic        v1_r;
  word_t       word1_r;
  logic        last1_r;

  // running state
  sum_first_t  f_r;
  sum_second_t s_r;
  count_t      cnt_r;

  // once-folded sums of a finished message
  logic        v2_r;
  fold_t       ff_r;
  fold_t       sf_r;

  // result stage
  logic        ov_r;
  checksum_t   ck_r;

  logic        ready_o;
  logic        ready2;
  logic        ready1;
  logic        mv1;
  logic        mv2;

  sum_first_t  f_add;
  sum_second_t s_add;
  count_t      cnt_inc;
  logic        blk_end;
  fold_t       f_fold;
  fold_t       s_fold;

  assign ready_o = !ov_r || out_ch.ready;
  assign ready2  = !v2_r || ready_o;
  assign mv1     = v1_r && (!last1_r || ready2);
  assign ready1  = !v1_r || mv1;
  assign mv2     = v2_r && ready_o;

  assign in_ch.ready     = ready1;
  assign out_ch.valid    = ov_r;
  assign out_ch.checksum = ck_r;

  assign f_add   = f_r + {8'b0, word1_r};
  assign s_add   = s_r + {8'b0, f_add};
  assign cnt_inc = cnt_r + 8'd1;
  assign blk_end = cnt_inc >= BlockWordsC;
  assign f_fold  = fold_first(f_add);
  assign s_fold  = fold_second(s_add);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      ov_r  <= 1'b0;
      f_r   <= FirstRearm;
      s_r   <= SecondRearm;
      cnt_r <= '0;
    end else begin
      if (ready1) begin
        v1_r <= in_ch.valid;
      end
      if (mv1) begin
        if (last1_r) begin
          f_r   <= FirstRearm;
          s_r   <= SecondRearm;
          cnt_r <= '0;
        end else if (blk_end) begin
          f_r   <= {7'b0, f_fold};
          s_r   <= {15'b0, s_fold};
          cnt_r <= '0;
        end else begin
          f_r   <= f_add;
          s_r   <= s_add;
          cnt_r <= cnt_inc;
        end
      end
      if (ready2) begin
        v2_r <= mv1 && last1_r;
      end
      if (ready_o) begin
        ov_r <= v2_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && ready1) begin
      word1_r <= in_ch.word;
      last1_r <= in_ch.last;
    end
    if (mv1 && last1_r) begin
      ff_r <= f_fold;
      sf_r <= s_fold;
    end
    if (mv2) begin
      ck_r <= {fold_final(sf_r), fold_final(ff_r)};
    end
  end

  a_cnt_below_block: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < BlockWordsC)
    else $error("block word count reached block size");

  a_last_to_fold: assert property (@(posedge clk) disable iff (!rst_n)
    (mv1 && last1_r) |=> v2_r)
    else $error("last word did not reach fold stage");

  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (mv1 && last1_r) |=> (f_r == FirstRearm && s_r == SecondRearm && cnt_r == '0))
    else $error("sums not re-armed after last word");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(v2_r))
    else $error("result appeared without a folded message");

endmodule

// File: tb/tb_fletcher32_checksum.sv
module tb_fletcher32_checksum;
  import fl32ck_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 11;
  localparam int BLOCK_WORDS    = 180;
  localparam int LATENCY_CYCLES = 2;
  localparam int MAX_WAIT       = 18;
  localparam int HOLD_CYCLES    = 200;
  localparam int PRESSURE_WORDS = 40;
  localparam int RANDOM_WORDS   = 790;
  localparam int TIMEOUT_CYCLES = 500000;
  localparam int DIRECTED_ROWS  = 20;

  typedef enum logic [1:0] {
    DATA_RANDOM,
    DATA_ONES,
    DATA_ZEROS,
    DATA_MIXED
  } data_mode_t;

  typedef struct packed {
    word_t     word;
    logic      last;
    logic      typed;
    checksum_t checksum;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fl32ck_in_if  in_ch ();
  fl32ck_out_if out_ch ();

  fletcher32_checksum #(.BLOCK_WORDS(BLOCK_WORDS)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // running sums of the checksum being built
  sum_first_t  run_first;
  sum_second_t run_second;
  count_t      run_count;

  checksum_t expected_checksums[$];
  int        errors = 0;
  int        words_sent = 0;
  bit        hold_output = 1'b0;
  bit        tx_steady = 1'b0;
  bit        rx_steady = 1'b0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{16'h0000, 1'b1, 1'b1, 32'hffffffff},
    '{16'hffff, 1'b1, 1'b1, 32'hffffffff},
    '{16'h0001, 1'b1, 1'b1, 32'h00010001},
    '{16'hfffe, 1'b1, 1'b1, 32'hfffefffe},
    '{16'hffff, 1'b0, 1'b0, 32'h0},
    '{16'hffff, 1'b0, 1'b0, 32'h0},
    '{16'hffff, 1'b1, 1'b0, 32'h0},
    '{16'h0000, 1'b0, 1'b0, 32'h0},
    '{16'h0000, 1'b1, 1'b0, 32'h0},
    '{16'h8000, 1'b0, 1'b0, 32'h0},
    '{16'h7fff, 1'b0, 1'b0, 32'h0},
    '{16'h1234, 1'b0, 1'b0, 32'h0},
    '{16'habcd, 1'b1, 1'b0, 32'h0},
    '{16'h0001, 1'b0, 1'b0, 32'h0},
    '{16'h0002, 1'b0, 1'b0, 32'h0},
    '{16'h0003, 1'b1, 1'b0, 32'h0},
    '{16'h00ff, 1'b0, 1'b0, 32'h0},
    '{16'hff00, 1'b1, 1'b0, 32'h0},
    '{16'h5555, 1'b0, 1'b0, 32'h0},
    '{16'haaaa, 1'b1, 1'b0, 32'h0}
  };

  function automatic sum_second_t end_around(input sum_second_t s);
    return {16'h0, s[15:0]} + {16'h0, s[31:16]};
  endfunction

  task automatic rearm_sums();
    run_first  = FirstRearm;
    run_second = SecondRearm;
    run_count  = '0;
  endtask

  task automatic fold_sums();
    sum_second_t folded;
    folded     = end_around({8'h0, run_first});
    run_first  = folded[23:0];
    run_second = end_around(run_second);
  endtask

  task automatic fletcher_update(input word_t w, input logic is_last,
                                 output logic done, output checksum_t sum);
    run_first  = run_first + {8'h0, w};
    run_second = run_second + {8'h0, run_first};
    run_count  = run_count + 8'd1;
    if (int'(run_count) >= BLOCK_WORDS || is_last) begin
      fold_sums();
      run_count = '0;
    end
    done = is_last;
    sum  = '0;
    if (is_last) begin
      fold_sums();
      sum = {run_second[15:0], run_first[15:0]};
      rearm_sums();
    end
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input word_t w, input logic is_last, input int gap,
                           input logic typed, input checksum_t typed_sum);
    logic      done;
    checksum_t sum;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.word  <= w;
    in_ch.last  <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    fletcher_update(w, is_last, done, sum);
    if (done) begin
      expected_checksums.insert(expected_checksums.size(), typed ? typed_sum : sum);
    end
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_checksums.size() != 0) @(negedge clk);
    repeat (LATENCY_CYCLES + 2) @(negedge clk);
  endtask

  task automatic send_message(input int len, input data_mode_t mode);
    word_t w;
    tx_steady = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      case (mode)
        DATA_ONES:  w = 16'hffff;
        DATA_ZEROS: w = 16'h0000;
        DATA_MIXED: begin
          case ($urandom_range(0, 3))
            0:       w = 16'hffff;
            1:       w = 16'h0000;
            default: w = word_t'($urandom);
          endcase
        end
        default:    w = word_t'($urandom);
      endcase
      send_word(w, i == len - 1, tx_steady ? 0 : $urandom_range(0, MAX_WAIT), 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    stim_row_t  row;
    data_mode_t mode;
    int         len;
    int         pick;
    int         msg_index;
    int         first_word;
    in_ch.valid = 1'b0;
    in_ch.word  = '0;
    in_ch.last  = 1'b0;
    rearm_sums();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_word(row.word, row.last, $urandom_range(0, MAX_WAIT), row.typed, row.checksum);
    end
    wait_drained();

    // output held off while two-word messages keep coming
    hold_output = 1'b1;
    for (int i = 0; i < PRESSURE_WORDS; i++) begin
      send_word(word_t'($urandom), i % 2 == 1, 0, 1'b0, '0);
    end
    wait_drained();

    msg_index  = 0;
    first_word = words_sent;
    while (words_sent - first_word < RANDOM_WORDS) begin
      pick = $urandom_range(0, 49);
      if (msg_index == 0) begin
        len = BLOCK_WORDS;
      end else if (msg_index == 1) begin
        len = 2 * BLOCK_WORDS;
      end else if (pick < 3) begin
        len = $urandom_range(BLOCK_WORDS - 2, BLOCK_WORDS + 2);
      end else if (pick == 3) begin
        len = $urandom_range(2 * BLOCK_WORDS - 1, 2 * BLOCK_WORDS + 1);
      end else if (pick < 10) begin
        len = 1;
      end else begin
        len = $urandom_range(2, 16);
      end
      mode = (msg_index == 0) ? DATA_ONES : data_mode_t'($urandom_range(0, 3));
      send_message(len, mode);
      if ($urandom_range(0, 9) == 0) begin
        wait_drained();
      end
      msg_index++;
    end
    wait_drained();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : receiver
    checksum_t want;
    int        gap;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_output) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_output = 1'b0;
        gap = 0;
      end else begin
        gap = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (expected_checksums.size() == 0) begin
        $display("%0t: checksum %h arrived with none expected", $time, out_ch.checksum);
        errors++;
      end else begin
        want = expected_checksums.pop_front();
        if (out_ch.checksum !== want) begin
          $display("%0t: checksum mismatch, expected %h, actual %h",
                   $time, want, out_ch.checksum);
          errors++;
        end
      end
      if ($urandom_range(0, 24) == 0) begin
        rx_steady = !rx_steady;
      end
      @(negedge clk);
    end
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("FAILURE");
    $finish;
  end

endmodule
